// ===== hw/rtl/csr_pkg.sv =====
// Shared types, codes and sizes for the collective status resolver.
package csr_pkg;

	localparam int MAX_PARTICIPANTS = 64;
	localparam int CNT_W = 7;
	localparam int CODE_W = 32;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PARTICIPANT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_ERROR_CODE = 1'd1;

	// Record dispositions
	localparam logic [1:0] DISP_SUCCESS = 2'd0;
	localparam logic [1:0] DISP_RETRY = 2'd1;
	localparam logic [1:0] DISP_FATAL = 2'd2;
	localparam logic [1:0] DISP_INVALID = 2'd3;

	// Decisions
	localparam logic [1:0] DEC_PROCEED = 2'd0;
	localparam logic [1:0] DEC_RETRY = 2'd1;
	localparam logic [1:0] DEC_FAIL = 2'd2;

	// Status codes; ST_OK also marks "no error recorded"
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RANK_RANGE = 3'd1;
	localparam logic [2:0] ST_BAD_DISP = 3'd2;
	localparam logic [2:0] ST_RANKS_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_EPOCH_MISMATCH = 3'd4;
	localparam logic [2:0] ST_PHASE_MISMATCH = 3'd5;

	typedef struct packed {
		logic [63:0] epoch;
		logic signed [31:0] rank;
		logic signed [31:0] endpoint;
		logic signed [31:0] code;
		logic [1:0] disposition;
		logic [31:0] phase_tag;
	} req_t;

	typedef struct packed {
		logic [1:0] decision;
		logic [2:0] status;
		logic [63:0] rep_epoch;
		logic signed [31:0] rep_rank;
		logic signed [31:0] rep_endpoint;
		logic signed [31:0] rep_code;
		logic [1:0] rep_disposition;
		logic [31:0] rep_phase_tag;
		logic [CNT_W-1:0] total_participants;
		logic [CNT_W-1:0] retry_total;
		logic [CNT_W-1:0] fatal_total;
	} rsp_t;

endpackage

// ===== hw/rtl/csr_stream_if.sv =====
// Valid/ready stream channel carrying one payload per request.
interface csr_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/csr_accum.sv =====
// Per-set accumulation: rank bitmap, tallies, error tracking and representative choice.
module csr_accum #(
	parameter int MaxParticipants = csr_pkg::MAX_PARTICIPANTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  csr_pkg::req_t                    item,
	input  logic [csr_pkg::CNT_W-1:0]        count_cfg,
	input  logic signed [csr_pkg::CODE_W-1:0] err_code,
	output logic                             close,
	output csr_pkg::rsp_t                    result
);

	localparam int IdxW = (MaxParticipants > 1) ? $clog2(MaxParticipants) : 1;
	localparam int CW = csr_pkg::CNT_W;

	logic [CW-1:0] seen_q;
	logic [MaxParticipants-1:0] map_q;
	logic dup_q;
	logic [63:0] first_epoch_q;
	logic [31:0] first_phase_q;
	logic [2:0] early_q;
	logic [2:0] late_q;
	logic [CW-1:0] retry_q;
	logic [CW-1:0] fatal_q;
	logic [2:0] best_valid_q;
	logic signed [31:0] best_rank_q [3];
	logic signed [31:0] best_endpoint_q [3];
	logic signed [31:0] best_code_q [3];

	logic [CW-1:0] count;
	logic first_rec;
	logic [63:0] fe;
	logic [31:0] fp;
	logic rank_ok;
	logic [IdxW-1:0] idx;
	logic [1:0] sel;
	logic disp_valid;
	logic less;
	logic upd;
	logic dup_n;
	logic [2:0] early_n;
	logic [2:0] late_n;
	logic [CW-1:0] retry_n;
	logic [CW-1:0] fatal_n;
	logic [CW-1:0] seen_n;
	logic [1:0] sev;
	logic rep_valid;
	logic signed [31:0] rep_r;
	logic signed [31:0] rep_e;
	logic signed [31:0] rep_c;
	logic [2:0] status;

	always_comb begin
		if (count_cfg == '0) begin
			count = CW'(1);
		end else if (32'(count_cfg) > MaxParticipants) begin
			count = CW'(MaxParticipants);
		end else begin
			count = count_cfg;
		end
	end

	assign first_rec = (seen_q == '0);
	assign fe = first_rec ? item.epoch : first_epoch_q;
	assign fp = first_rec ? item.phase_tag : first_phase_q;
	assign rank_ok = !item.rank[31] && (item.rank[30:0] < 31'(count));
	assign idx = item.rank[IdxW-1:0];
	assign disp_valid = (item.disposition != csr_pkg::DISP_INVALID);
	assign sel = disp_valid ? item.disposition : csr_pkg::DISP_SUCCESS;

	// Lexicographic (rank, endpoint, code) compare against the stored best
	always_comb begin
		if ($signed(item.rank) != best_rank_q[sel]) begin
			less = $signed(item.rank) < best_rank_q[sel];
		end else if ($signed(item.endpoint) != best_endpoint_q[sel]) begin
			less = $signed(item.endpoint) < best_endpoint_q[sel];
		end else begin
			less = $signed(item.code) < best_code_q[sel];
		end
	end

	assign upd = rank_ok && disp_valid && (!best_valid_q[sel] || less);
	assign dup_n = dup_q | (rank_ok & map_q[idx]);

	always_comb begin
		early_n = early_q;
		if (early_q == csr_pkg::ST_OK) begin
			if (!rank_ok) begin
				early_n = csr_pkg::ST_RANK_RANGE;
			end else if (!disp_valid) begin
				early_n = csr_pkg::ST_BAD_DISP;
			end
		end
		late_n = late_q;
		if (late_q == csr_pkg::ST_OK) begin
			if (item.epoch != fe) begin
				late_n = csr_pkg::ST_EPOCH_MISMATCH;
			end else if (item.phase_tag != fp) begin
				late_n = csr_pkg::ST_PHASE_MISMATCH;
			end
		end
	end

	assign retry_n = retry_q + CW'(item.disposition == csr_pkg::DISP_RETRY);
	assign fatal_n = fatal_q + CW'(item.disposition == csr_pkg::DISP_FATAL);
	assign seen_n = seen_q + CW'(1);
	assign close = ({1'b0, seen_n} >= {1'b0, count});

	// Worst severity present, with this record folded in
	assign sev = (fatal_n != '0) ? csr_pkg::DISP_FATAL :
		((retry_n != '0) ? csr_pkg::DISP_RETRY : csr_pkg::DISP_SUCCESS);

	always_comb begin
		if (upd && sel == sev) begin
			rep_valid = 1'b1;
			rep_r = item.rank;
			rep_e = item.endpoint;
			rep_c = item.code;
		end else begin
			rep_valid = best_valid_q[sev];
			rep_r = best_rank_q[sev];
			rep_e = best_endpoint_q[sev];
			rep_c = best_code_q[sev];
		end
	end

	always_comb begin
		if (early_n != csr_pkg::ST_OK) begin
			status = early_n;
		end else if (dup_n) begin
			status = csr_pkg::ST_RANKS_INCOMPLETE;
		end else begin
			status = late_n;
		end
	end

	always_comb begin
		result.rep_epoch = fe;
		result.total_participants = seen_n;
		result.status = status;
		if (status != csr_pkg::ST_OK) begin
			result.decision = csr_pkg::DEC_FAIL;
			result.rep_rank = '1;
			result.rep_endpoint = '1;
			result.rep_code = err_code;
			result.rep_disposition = csr_pkg::DISP_FATAL;
			result.rep_phase_tag = '0;
			result.retry_total = '0;
			result.fatal_total = CW'(1);
		end else begin
			result.decision = sev;
			result.rep_rank = rep_valid ? rep_r : '0;
			result.rep_endpoint = rep_valid ? rep_e : '0;
			result.rep_code = rep_valid ? rep_c : '0;
			result.rep_disposition = sev;
			result.rep_phase_tag = fp;
			result.retry_total = retry_n;
			result.fatal_total = fatal_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			map_q <= '0;
			dup_q <= 1'b0;
			early_q <= csr_pkg::ST_OK;
			late_q <= csr_pkg::ST_OK;
			retry_q <= '0;
			fatal_q <= '0;
			best_valid_q <= '0;
		end else if (adv) begin
			if (close) begin
				seen_q <= '0;
				map_q <= '0;
				dup_q <= 1'b0;
				early_q <= csr_pkg::ST_OK;
				late_q <= csr_pkg::ST_OK;
				retry_q <= '0;
				fatal_q <= '0;
				best_valid_q <= '0;
			end else begin
				seen_q <= seen_n;
				if (rank_ok) begin
					map_q[idx] <= 1'b1;
				end
				dup_q <= dup_n;
				early_q <= early_n;
				late_q <= late_n;
				retry_q <= retry_n;
				fatal_q <= fatal_n;
				if (upd) begin
					best_valid_q[sel] <= 1'b1;
				end
			end
		end
	end

	// Payload holds; valid bits above decide whether it is read
	always_ff @(posedge clk) begin
		if (adv) begin
			if (first_rec) begin
				first_epoch_q <= item.epoch;
				first_phase_q <= item.phase_tag;
			end
			if (upd) begin
				best_rank_q[sel] <= item.rank;
				best_endpoint_q[sel] <= item.endpoint;
				best_code_q[sel] <= item.code;
			end
		end
	end

endmodule

// ===== hw/rtl/collective_status_resolver.sv =====
// Top level: input register, set accumulator, result register and config registers.
//
//   channel  dir  payload            handshake
//   req      in   csr_pkg::req_t     valid/ready, one status record per request
//   rsp      out  csr_pkg::rsp_t     valid/ready, one result per completed set
//   cfg      in   count, error code  cfg_we with cfg_index/cfg_wdata, no stall
//
// One record per cycle, sustained, unless a waiting result stalls it (see below).
// A record is held in the input register; when it advances it updates the set
// state and, if it closes the set, loads the result into the output register,
// from which the result is offered.
// arst_n clears the set state, the registers to their defaults and both valids.
// A waiting result stalls only the record that would close the next set.
module collective_status_resolver #(
	parameter int MaxParticipants = csr_pkg::MAX_PARTICIPANTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	csr_stream_if.sink                            req,
	csr_stream_if.source                          rsp,
	input  logic                                  cfg_we,
	input  logic [csr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csr_pkg::CODE_W-1:0]            cfg_wdata
);

	logic [csr_pkg::CNT_W-1:0] count_q;
	logic signed [csr_pkg::CODE_W-1:0] err_code_q;

	logic valid_s1;
	csr_pkg::req_t item_s1;
	logic adv;
	logic close;
	csr_pkg::rsp_t result;
	logic out_valid_q;
	csr_pkg::rsp_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= csr_pkg::CNT_W'(1);
			err_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csr_pkg::CFG_PARTICIPANT_COUNT: begin
					count_q <= cfg_wdata[csr_pkg::CNT_W-1:0];
				end
				csr_pkg::CFG_PROTOCOL_ERROR_CODE: begin
					err_code_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the held request unless it closes a set while a result waits
	assign adv = valid_s1 && (!close || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	csr_accum #(
		.MaxParticipants(MaxParticipants)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.item(item_s1),
		.count_cfg(count_q),
		.err_code(err_code_q),
		.close(close),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && close) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && close) begin
			out_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the collective status resolver: directed sets, then random sets.
module tb_top;
	import csr_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0] cfg_wdata;

	csr_stream_if #(.payload_t(req_t)) req_if ();
	csr_stream_if #(.payload_t(rsp_t)) rsp_if ();

	collective_status_resolver dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	bit steady = 1'b0;
	rsp_t pending_verdicts[$];

	// Shadow of the configuration and of the set being gathered
	logic [CNT_W-1:0] part_count;
	logic [31:0] fail_code;
	int seen_cnt;
	logic [63:0] rank_map;
	bit dup_rank;
	logic [63:0] set_epoch;
	logic [31:0] set_phase;
	logic [2:0] early_st;
	logic [2:0] late_st;
	int retries;
	int fatals;
	bit best_ok[3];
	int best_rank[3];
	int best_endpoint[3];
	int best_code[3];

	function automatic void clear_set();
		seen_cnt = 0;
		rank_map = '0;
		dup_rank = 1'b0;
		set_epoch = '0;
		set_phase = '0;
		early_st = ST_OK;
		late_st = ST_OK;
		retries = 0;
		fatals = 0;
		for (int s = 0; s < 3; s++) begin
			best_ok[s] = 1'b0;
			best_rank[s] = 0;
			best_endpoint[s] = 0;
			best_code[s] = 0;
		end
	endfunction

	function automatic bit key_below(int s, int rk, int ep, int cd);
		if (rk != best_rank[s]) return rk < best_rank[s];
		if (ep != best_endpoint[s]) return ep < best_endpoint[s];
		return cd < best_code[s];
	endfunction

	// Fold one accepted record into the set; queue the verdict when the set closes.
	function automatic void resolve_record(input req_t r);
		int lim, rk, ep, cd, sev;
		rsp_t v;
		lim = (part_count == 0) ? 1 :
			(int'(part_count) > MAX_PARTICIPANTS) ? MAX_PARTICIPANTS : int'(part_count);
		rk = r.rank;
		ep = r.endpoint;
		cd = r.code;
		if (seen_cnt == 0) begin
			set_epoch = r.epoch;
			set_phase = r.phase_tag;
		end
		if (rk < 0 || rk >= lim) begin
			if (early_st == ST_OK) early_st = ST_RANK_RANGE;
		end else begin
			if (rank_map[rk]) dup_rank = 1'b1;
			rank_map[rk] = 1'b1;
			if (r.disposition == DISP_INVALID) begin
				if (early_st == ST_OK) early_st = ST_BAD_DISP;
			end else begin
				sev = int'(r.disposition);
				if (!best_ok[sev] || key_below(sev, rk, ep, cd)) begin
					best_ok[sev] = 1'b1;
					best_rank[sev] = rk;
					best_endpoint[sev] = ep;
					best_code[sev] = cd;
				end
			end
		end
		if (late_st == ST_OK) begin
			if (r.epoch != set_epoch) late_st = ST_EPOCH_MISMATCH;
			else if (r.phase_tag != set_phase) late_st = ST_PHASE_MISMATCH;
		end
		if (r.disposition == DISP_RETRY) retries++;
		if (r.disposition == DISP_FATAL) fatals++;
		seen_cnt++;
		if (seen_cnt < lim) return;

		v.status = (early_st != ST_OK) ? early_st : dup_rank ? ST_RANKS_INCOMPLETE : late_st;
		v.rep_epoch = set_epoch;
		v.total_participants = seen_cnt[CNT_W-1:0];
		if (v.status != ST_OK) begin
			v.decision = DEC_FAIL;
			v.rep_rank = -1;
			v.rep_endpoint = -1;
			v.rep_code = fail_code;
			v.rep_disposition = DISP_FATAL;
			v.rep_phase_tag = '0;
			v.retry_total = '0;
			v.fatal_total = CNT_W'(1);
		end else begin
			if (fatals != 0) begin
				v.decision = DEC_FAIL;
				v.rep_disposition = DISP_FATAL;
			end else if (retries != 0) begin
				v.decision = DEC_RETRY;
				v.rep_disposition = DISP_RETRY;
			end else begin
				v.decision = DEC_PROCEED;
				v.rep_disposition = DISP_SUCCESS;
			end
			sev = int'(v.rep_disposition);
			v.rep_rank = best_rank[sev];
			v.rep_endpoint = best_endpoint[sev];
			v.rep_code = best_code[sev];
			v.rep_phase_tag = set_phase;
			v.retry_total = retries[CNT_W-1:0];
			v.fatal_total = fatals[CNT_W-1:0];
		end
		pending_verdicts.push_back(v);
		clear_set();
	endfunction

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
		end
	endtask

	// Observe config writes, accepted requests and results at each edge.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PARTICIPANT_COUNT: part_count = cfg_wdata[CNT_W-1:0];
					CFG_PROTOCOL_ERROR_CODE: fail_code = cfg_wdata;
					default: ;
				endcase
			end
			// Check the result before folding in a request that may close another set
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_verdicts.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h", $time,
						rsp_if.data);
				end else begin
					want = pending_verdicts.pop_front();
					check_field("decision", want.decision, rsp_if.data.decision);
					check_field("status", want.status, rsp_if.data.status);
					check_field("rep_epoch", want.rep_epoch, rsp_if.data.rep_epoch);
					check_field("rep_rank", want.rep_rank, rsp_if.data.rep_rank);
					check_field("rep_endpoint", want.rep_endpoint, rsp_if.data.rep_endpoint);
					check_field("rep_code", want.rep_code, rsp_if.data.rep_code);
					check_field("rep_disposition", want.rep_disposition,
						rsp_if.data.rep_disposition);
					check_field("rep_phase_tag", want.rep_phase_tag, rsp_if.data.rep_phase_tag);
					check_field("total_participants", want.total_participants,
						rsp_if.data.total_participants);
					check_field("retry_total", want.retry_total, rsp_if.data.retry_total);
					check_field("fatal_total", want.fatal_total, rsp_if.data.fatal_total);
				end
			end
			if (req_if.valid && req_if.ready) resolve_record(req_if.data);
		end
	end

	always @(posedge clk) rsp_if.ready <= steady || ($urandom_range(99) >= 36);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic req_t rec(input logic [63:0] epoch, input int rank, input int endpoint,
			input int code, input logic [1:0] disp, input logic [31:0] phase);
		req_t r;
		r.epoch = epoch;
		r.rank = rank;
		r.endpoint = endpoint;
		r.code = code;
		r.disposition = disp;
		r.phase_tag = phase;
		return r;
	endfunction

	task automatic send_record(input req_t r);
		while (!steady && $urandom_range(99) < 36) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
	endtask

	// Drop valid, wait out every expected result, then let the pipeline empty.
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_defaults();
		send_record(rec('1, 0, 32'h8000_0000, 32'h7FFF_FFFF, DISP_SUCCESS, '1));
	endtask

	task automatic test_count_floor();
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 0);
		send_record(rec('0, 0, 32'h7FFF_FFFF, 32'h8000_0000, DISP_RETRY, '0));
		send_record(rec(64'd1, 1, 4, 5, DISP_SUCCESS, 32'd7));
	endtask

	task automatic test_severity_pick();
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 3);
		write_reg(CFG_PROTOCOL_ERROR_CODE, 32'h8000_0000);
		send_record(rec(64'h55, 2, 5, 9, DISP_FATAL, 32'h11));
		send_record(rec(64'h55, 0, -7, 1, DISP_RETRY, 32'h11));
		send_record(rec(64'h55, 1, -3, -2, DISP_FATAL, 32'h11));
	endtask

	task automatic test_early_errors();
		// Out-of-range rank and invalid disposition in one record: the rank wins
		send_record(rec(64'h9, 0, 1, 1, DISP_SUCCESS, 32'h3));
		send_record(rec(64'h9, 5, 1, 1, DISP_INVALID, 32'h3));
		send_record(rec(64'h9, 1, 1, 1, DISP_INVALID, 32'h3));
		// Bad disposition first, out-of-range rank later
		send_record(rec(64'h9, 0, 1, 1, DISP_INVALID, 32'h3));
		send_record(rec(64'h9, 32'h7FFF_FFFF, 1, 1, DISP_SUCCESS, 32'h3));
		send_record(rec(64'h9, 2, 1, 1, DISP_SUCCESS, 32'h3));
	endtask

	task automatic test_rank_coverage();
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 2);
		write_reg(CFG_PROTOCOL_ERROR_CODE, 32'h7FFF_FFFF);
		// Repeated rank outranks the epoch mismatch
		send_record(rec(64'h20, 0, 3, 3, DISP_SUCCESS, 32'h8));
		send_record(rec(64'h21, 0, 2, 2, DISP_RETRY, 32'h8));
	endtask

	task automatic test_late_errors();
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 3);
		send_record(rec(64'hA0, 0, 0, 0, DISP_SUCCESS, 32'hC0));
		send_record(rec(64'hA1, 1, 0, 0, DISP_SUCCESS, 32'hC1));
		send_record(rec(64'hA0, 2, 0, 0, DISP_SUCCESS, 32'hC2));
		send_record(rec(64'hB0, 2, 0, 0, DISP_SUCCESS, 32'hD0));
		send_record(rec(64'hB0, 0, 0, 0, DISP_SUCCESS, 32'hD0));
		send_record(rec(64'hB0, 1, 0, 0, DISP_SUCCESS, 32'hD1));
	endtask

	task automatic test_count_shrink_mid_set();
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 4);
		send_record(rec(64'h7, 0, 0, 0, DISP_SUCCESS, 32'h1));
		send_record(rec(64'h7, 1, 0, 0, DISP_SUCCESS, 32'h1));
		send_record(rec(64'h7, 2, 0, 0, DISP_SUCCESS, 32'h1));
		settle();
		write_reg(CFG_PARTICIPANT_COUNT, 2);
		// Rank 3 was legal under the old count; this record closes the set
		send_record(rec(64'h7, 3, 0, 0, DISP_SUCCESS, 32'h1));
	endtask

	task automatic run_set(input int n);
		req_t recs[$];
		int perm[$];
		int i, j, k, t, mode, mix, kind;
		logic [63:0] ep;
		logic [31:0] ph;
		req_t r;
		for (i = 0; i < n; i++) perm.push_back(i);
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		ep = {$urandom, $urandom};
		ph = $urandom;
		mix = $urandom_range(2);
		for (i = 0; i < n; i++) begin
			r.epoch = ep;
			r.rank = perm[i];
			r.endpoint = $urandom;
			r.code = $urandom;
			r.phase_tag = ph;
			t = $urandom_range(5);
			if (mix == 0) r.disposition = DISP_SUCCESS;
			else if (mix == 1) r.disposition = (t < 2) ? DISP_RETRY : DISP_SUCCESS;
			else r.disposition = (t == 0) ? DISP_FATAL : (t < 3) ? DISP_RETRY : DISP_SUCCESS;
			recs.push_back(r);
		end
		mode = $urandom_range(99);
		if (mode >= 90) begin
			for (i = 0; i < n; i++) begin
				if ($urandom_range(1)) recs[i].rank = $urandom;
				recs[i].disposition = 2'($urandom_range(3));
				if ($urandom_range(1)) recs[i].epoch = {$urandom, $urandom};
				if ($urandom_range(1)) recs[i].phase_tag = $urandom;
			end
		end else if (mode >= 70) begin
			repeat ($urandom_range(1, 2)) begin
				kind = $urandom_range(4);
				if (n == 1 && kind >= 2) kind = 0;
				j = $urandom_range(n - 1);
				case (kind)
					0: recs[j].disposition = DISP_INVALID;
					1: begin
						if ($urandom_range(1)) begin
							recs[j].rank = $urandom | 32'h8000_0000;
						end else begin
							t = $urandom & 32'h7FFF_FFFF;
							if (t < n) t = t + n;
							recs[j].rank = t;
						end
					end
					2: begin
						k = (j + $urandom_range(1, n - 1)) % n;
						recs[j].rank = recs[k].rank;
					end
					3: begin
						j = $urandom_range(1, n - 1);
						recs[j].epoch = recs[j].epoch ^ ({$urandom, $urandom} | 64'd1);
					end
					default: begin
						j = $urandom_range(1, n - 1);
						recs[j].phase_tag = recs[j].phase_tag ^ ($urandom | 32'd1);
					end
				endcase
			end
		end
		foreach (recs[i]) send_record(recs[i]);
	endtask

	task automatic test_random_sets();
		int phase_no, start, cnt, n, sets, pick;
		logic [31:0] code;
		phase_no = 0;
		start = items_sent;
		while (items_sent < start + RANDOM_ITEMS) begin
			settle();
			pick = $urandom_range(99);
			case (phase_no)
				0: cnt = 127;
				1: cnt = 64;
				2: cnt = 0;
				default: begin
					if (pick < 70) cnt = $urandom_range(1, 6);
					else if (pick < 90) cnt = $urandom_range(7, 20);
					else if (pick < 95) cnt = $urandom_range(21, 64);
					else cnt = $urandom_range(65, 127);
				end
			endcase
			write_reg(CFG_PARTICIPANT_COUNT, cnt);
			pick = $urandom_range(3);
			code = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF : $urandom;
			if (phase_no < 2 || $urandom_range(1)) write_reg(CFG_PROTOCOL_ERROR_CODE, code);
			n = (cnt == 0) ? 1 : (cnt > MAX_PARTICIPANTS) ? MAX_PARTICIPANTS : cnt;
			sets = (n > 16) ? 1 : $urandom_range(2, 40 / n);
			repeat (sets) begin
				// Hold a long stretch with no idling on either side
				steady = (items_sent >= start + 200) && (items_sent < start + 330);
				run_set(n);
			end
			phase_no++;
		end
		steady = 1'b0;
	endtask

	initial begin
		part_count = 1;
		fail_code = '0;
		clear_set();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PARTICIPANT_COUNT;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_count_floor();
		test_severity_pick();
		test_early_errors();
		test_rank_coverage();
		test_late_errors();
		test_count_shrink_mid_set();
		test_random_sets();
		settle();

		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/csr_pkg.sv
hw/rtl/csr_stream_if.sv
hw/rtl/csr_accum.sv
hw/rtl/collective_status_resolver.sv
verif/tb_top.sv
